/* design/html_word_tokenizer_unit_assert.svh */
// Assertion macros for the word tokenizer core RTL.
`ifndef HTML_WORD_TOKENIZER_UNIT_ASSERT_SVH
`define HTML_WORD_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define HTOK_CHECK_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("htok: same-cycle check failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define HTOK_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("htok: next-cycle check failed");

`endif

/* design/htok_pkg.sv */
// Types and constants shared by the word tokenizer modules.
package htok_pkg;

   localparam int TEXT_BITS        = 8;
   localparam int WORD_LENGTH_BITS = 16;

   localparam int  CSR_ADDR_BITS = 3;
   localparam int  CSR_DATA_BITS = 32;
   localparam logic CSR_IDX_HIGH_BYTES = 1'b0;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_TAG,
      MODE_ENT,
      MODE_WORD,
      MODE_WTAG,
      MODE_WAFTER
   } mode_type;

   localparam int ONE_LETTER_COUNT = 5;
   localparam logic [ONE_LETTER_COUNT-1:0][7:0] ONE_LETTER_TAGS = "abisu";

   // Inline tag names, left-justified and padded with spaces.
   localparam int INLINE_COUNT = 16;
   localparam int INLINE_MAX   = 9;
   typedef logic [INLINE_MAX-1:0][7:0] tag_text_type;

   localparam tag_text_type INLINE_TXT [INLINE_COUNT] = '{
      "basefont ", "big      ", "blink    ", "cite     ",
      "code     ", "em       ", "font     ", "kbd      ",
      "plaintext", "small    ", "strike   ", "strong   ",
      "sub      ", "sup      ", "tt       ", "var      "
   };

   localparam logic [3:0] INLINE_LEN [INLINE_COUNT] = '{
      4'd8, 4'd3, 4'd5, 4'd4, 4'd4, 4'd2, 4'd4, 4'd3,
      4'd9, 4'd5, 4'd6, 4'd6, 4'd3, 4'd3, 4'd2, 4'd3
   };

endpackage

/* design/htok_if.sv */
// Valid/ready channel interfaces for text bytes and tokenizer results.
interface htok_req_if;
   logic                          valid;
   logic                          ready;
   logic [htok_pkg::TEXT_BITS-1:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

interface htok_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic [htok_pkg::TEXT_BITS-1:0]        char_value;
   logic [htok_pkg::WORD_LENGTH_BITS-1:0] word_length;
   logic                                 last;

   modport source (output valid, output kind, output char_value, output word_length,
                   output last, input ready);
   modport sink (input valid, input kind, input char_value, input word_length,
                 input last, output ready);
endinterface

/* design/html_word_tokenizer_unit.sv */
// Top level of the HTML word tokenizer.
//
// Text bytes arrive on req_chan, one per beat; results leave on rsp_chan.
// Each byte yields at most one result: a word character (kind 0) carrying
// the byte, or an end of word (kind 1) carrying the word length, which
// saturates at 2^LENGTH_BITS-1. Tags, entities, spaces and punctuation
// give no word-character result. Every result has last set.
// A byte taken is held in the input register and parsed into the result
// register once that register can take it. One byte is accepted per cycle
// when the output side keeps up; the parse state update and the inline
// tag-name compare sit between the input and result registers. When the
// receiver stalls, the result register holds and the input register holds
// the next byte, so ready drops only while both are full.
// A zero byte ends the document and returns the parse to its idle state.
// Reset clears the parse and the high_bytes_letters register; the APB
// port writes that register (address 0). The user must write it only while
// the block is idle; the block itself does not enforce this.
module html_word_tokenizer_unit #(
   parameter int NAME_CHARS  = 9,
   parameter int LENGTH_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   htok_req_if.sink                            req_chan,
   htok_rsp_if.source                          rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [htok_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [htok_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [htok_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready
);
   import htok_pkg::*;

   logic high_bytes_letters;

   htok_csr_regs u_csr_regs (
      .clock              (clock),
      .reset              (reset),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .high_bytes_letters (high_bytes_letters)
   );

   htok_core #(
      .NAME_CHARS  (NAME_CHARS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .high_bytes_letters (high_bytes_letters),
      .req_chan           (req_chan),
      .rsp_chan           (rsp_chan)
   );

endmodule

/* design/htok_csr_regs.sv */
// Configuration register block behind the APB-style port.
module htok_csr_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [htok_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [htok_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [htok_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready,
   output logic                                high_bytes_letters
);
   import htok_pkg::*;

   logic high_bytes_ff;
   logic high_bytes_in;
   logic reg_sel;

   // Word index is the address above the byte offset.
   assign reg_sel = (paddr[CSR_ADDR_BITS-1] == CSR_IDX_HIGH_BYTES);

   always_comb begin
      high_bytes_in = high_bytes_ff;
      if (psel && penable && pwrite && reg_sel) begin
         high_bytes_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_bytes_ff <= 1'b0;
      end else begin
         high_bytes_ff <= high_bytes_in;
      end
   end

   assign prdata = reg_sel ? {{(CSR_DATA_BITS-1){1'b0}}, high_bytes_ff} : '0;
   assign pready = 1'b1;
   assign high_bytes_letters = high_bytes_ff;

endmodule

/* design/htok_name_match.sv */
// Parallel compare of the collected tag name against the inline tag list.
module htok_name_match #(
   parameter int NAME_CHARS  = 9,
   parameter int COUNT_BITS  = 4
) (
   input  logic [NAME_CHARS-1:0][7:0] name_store,
   input  logic [COUNT_BITS-1:0]      name_count,
   output logic                       is_inline
);
   import htok_pkg::*;

   logic                    one_letter;
   logic [INLINE_COUNT-1:0] hit;

   always_comb begin
      one_letter = 1'b0;
      for (int i = 0; i < ONE_LETTER_COUNT; i++) begin
         if (name_store[0] == ONE_LETTER_TAGS[i]) begin
            one_letter = 1'b1;
         end
      end
      for (int k = 0; k < INLINE_COUNT; k++) begin
         hit[k] = (name_count == COUNT_BITS'(INLINE_LEN[k]));
         // Only the characters below the name length take part.
         for (int j = 0; j < INLINE_MAX; j++) begin
            if (j < int'(INLINE_LEN[k]) && name_store[j] != INLINE_TXT[k][INLINE_MAX-1-j]) begin
               hit[k] = 1'b0;
            end
         end
      end
      is_inline = (name_count == COUNT_BITS'(1)) ? one_letter : (|hit);
   end

endmodule

/* design/htok_core.sv */
// Tokenizer datapath: input register, parse state update and result register.
module htok_core #(
   parameter int NAME_CHARS  = 9,
   parameter int LENGTH_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       high_bytes_letters,
   htok_req_if.sink   req_chan,
   htok_rsp_if.source rsp_chan
);
   import htok_pkg::*;

   `include "html_word_tokenizer_unit_assert.svh"

   localparam int COUNT_BITS = $clog2(NAME_CHARS + 1);
   localparam int INDEX_BITS = $clog2(NAME_CHARS);
   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

   logic                          in_valid_ff, in_valid_in;
   logic [7:0]                    in_byte_ff;
   logic                          out_valid_ff, out_valid_in;
   logic                          out_kind_ff;
   logic [7:0]                    out_char_ff;
   logic [WORD_LENGTH_BITS-1:0]   out_len_ff;

   mode_type                      mode_ff, mode_in;
   logic [NAME_CHARS-1:0][7:0]    name_store_ff;
   logic [COUNT_BITS-1:0]         name_count_ff, name_count_in;
   logic                          name_open_ff, name_open_in;
   logic                          slash_ok_ff, slash_ok_in;
   logic [LENGTH_BITS-1:0]        word_count_ff, word_count_in;

   logic                          advance;
   logic                          word_byte;
   logic                          tag_is_inline;
   logic                          slash_skip;
   logic                          name_take;
   logic                          emit;
   logic                          emit_end;
   logic [LENGTH_BITS-1:0]        count_step;
   logic [7:0]                    lower_byte;

   function automatic logic is_word(input logic [7:0] c, input logic high);
      logic res;
      res = (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
            (high && c[7]);
      return res;
   endfunction

   // Mode taken by a byte seen outside any word and scan.
   function automatic mode_type idle_mode(input logic [7:0] c, input logic wb);
      mode_type m;
      if (c == CH_LT) begin
         m = MODE_TAG;
      end else if (c == CH_AMP) begin
         m = MODE_ENT;
      end else if (wb) begin
         m = MODE_WORD;
      end else begin
         m = MODE_IDLE;
      end
      return m;
   endfunction

   htok_name_match #(
      .NAME_CHARS (NAME_CHARS),
      .COUNT_BITS (COUNT_BITS)
   ) u_name_match (
      .name_store (name_store_ff),
      .name_count (name_count_ff),
      .is_inline  (tag_is_inline)
   );

   // The held byte is processed once the result register can take its beat.
   assign advance          = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !in_valid_ff || advance;
   assign word_byte        = is_word(in_byte_ff, high_bytes_letters);
   assign count_step       = (word_count_ff == COUNT_MAX) ? word_count_ff
                                                          : word_count_ff + 1'b1;
   assign lower_byte       = (in_byte_ff >= "A" && in_byte_ff <= "Z") ? (in_byte_ff | 8'h20)
                                                                      : in_byte_ff;
   assign slash_skip       = name_open_ff && slash_ok_ff && (name_count_ff == '0) &&
                             (in_byte_ff == CH_SLASH);
   assign name_take        = !slash_skip && name_open_ff && word_byte &&
                             (name_count_ff < COUNT_BITS'(NAME_CHARS));

   // Next parse mode.
   always_comb begin
      mode_in = mode_ff;
      if (in_byte_ff == CH_NUL) begin
         mode_in = MODE_IDLE;
      end else begin
         case (mode_ff)
            MODE_TAG: begin
               if (in_byte_ff == CH_GT) mode_in = MODE_IDLE;
            end
            MODE_ENT: begin
               if (in_byte_ff == CH_SEMI) mode_in = MODE_IDLE;
            end
            MODE_WORD: begin
               if (in_byte_ff == CH_LT) begin
                  mode_in = MODE_WTAG;
               end else if (!word_byte) begin
                  mode_in = idle_mode(in_byte_ff, word_byte);
               end
            end
            MODE_WTAG: begin
               if (in_byte_ff == CH_GT) begin
                  mode_in = tag_is_inline ? MODE_WAFTER : MODE_IDLE;
               end
            end
            MODE_WAFTER: begin
               mode_in = word_byte ? MODE_WORD : idle_mode(in_byte_ff, word_byte);
            end
            default: begin
               mode_in = idle_mode(in_byte_ff, word_byte);
            end
         endcase
      end
   end

   // Results and the rest of the parse state.
   always_comb begin
      emit          = 1'b0;
      emit_end      = 1'b0;
      word_count_in = word_count_ff;
      name_count_in = name_count_ff;
      name_open_in  = name_open_ff;
      slash_ok_in   = slash_ok_ff;
      if (in_byte_ff == CH_NUL) begin
         if (mode_ff == MODE_WORD || mode_ff == MODE_WTAG || mode_ff == MODE_WAFTER) begin
            emit     = 1'b1;
            emit_end = 1'b1;
         end
         word_count_in = '0;
         name_count_in = '0;
         name_open_in  = 1'b1;
         slash_ok_in   = 1'b1;
      end else begin
         case (mode_ff)
            MODE_TAG, MODE_ENT: begin
            end
            MODE_WORD: begin
               if (word_byte) begin
                  emit          = 1'b1;
                  word_count_in = count_step;
               end else if (in_byte_ff == CH_LT) begin
                  name_count_in = '0;
                  name_open_in  = 1'b1;
                  slash_ok_in   = 1'b1;
               end else begin
                  emit          = 1'b1;
                  emit_end      = 1'b1;
                  word_count_in = '0;
               end
            end
            MODE_WTAG: begin
               if (in_byte_ff == CH_GT) begin
                  if (!tag_is_inline) begin
                     emit          = 1'b1;
                     emit_end      = 1'b1;
                     word_count_in = '0;
                  end
               end else begin
                  if (name_take) begin
                     name_count_in = name_count_ff + 1'b1;
                  end else if (!slash_skip) begin
                     name_open_in = 1'b0;
                  end
                  slash_ok_in = 1'b0;
               end
            end
            MODE_WAFTER: begin
               emit = 1'b1;
               if (word_byte) begin
                  word_count_in = count_step;
               end else begin
                  emit_end      = 1'b1;
                  word_count_in = '0;
               end
            end
            default: begin
               if (word_byte) begin
                  emit          = 1'b1;
                  word_count_in = LENGTH_BITS'(1);
               end
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (advance) begin
         out_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         mode_ff       <= MODE_IDLE;
         name_count_ff <= '0;
         name_open_ff  <= 1'b1;
         slash_ok_ff   <= 1'b1;
         word_count_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mode_ff       <= mode_in;
            name_count_ff <= name_count_in;
            name_open_ff  <= name_open_in;
            slash_ok_ff   <= slash_ok_in;
            word_count_ff <= word_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.text_byte;
      end
      if (advance && emit) begin
         out_kind_ff <= emit_end;
         out_char_ff <= emit_end ? 8'h00 : in_byte_ff;
         out_len_ff  <= emit_end ? WORD_LENGTH_BITS'(word_count_ff) : '0;
      end
      if (advance && mode_ff == MODE_WTAG && in_byte_ff != CH_NUL && in_byte_ff != CH_GT &&
          name_take) begin
         name_store_ff[name_count_ff[INDEX_BITS-1:0]] <= lower_byte;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.kind        = out_kind_ff;
   assign rsp_chan.char_value  = out_char_ff;
   assign rsp_chan.word_length = out_len_ff;
   assign rsp_chan.last        = 1'b1;

   // Outside a word the length counter is always clear, inside it never is.
   `HTOK_CHECK_SAME(a_count_clear_outside, (mode_ff == MODE_IDLE || mode_ff == MODE_TAG || mode_ff == MODE_ENT), (word_count_ff == '0))
   `HTOK_CHECK_SAME(a_count_set_inside, (mode_ff == MODE_WORD || mode_ff == MODE_WTAG || mode_ff == MODE_WAFTER), (word_count_ff != '0))
   `HTOK_CHECK_NEXT(a_end_leaves_word, (advance && emit && emit_end), (mode_ff == MODE_IDLE || mode_ff == MODE_TAG || mode_ff == MODE_ENT))
   `HTOK_CHECK_SAME(a_name_count_bound, (mode_ff == MODE_WTAG), (name_count_ff <= COUNT_BITS'(NAME_CHARS)))

endmodule

/* tb/html_word_tokenizer_unit_tb.sv */
// Self-checking testbench for the HTML word tokenizer with a predicting scoreboard.
module html_word_tokenizer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import htok_pkg::*;

   localparam int NAME_CHARS = 9;
   localparam int unsigned LENGTH_MAX = (1 << WORD_LENGTH_BITS) - 1;
   localparam int unsigned CYCLE_LIMIT = 100000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD = 80;
   localparam int LONG_WORD = 200;
   localparam logic [CSR_ADDR_BITS-1:0] HIGH_BYTES_ADDR =
      CSR_ADDR_BITS'(4 * CSR_IDX_HIGH_BYTES);
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Inline formatting tags that do not break a word.
   localparam string INLINE_NAMES [21] = '{
      "a", "b", "i", "s", "u", "basefont", "big", "blink", "cite", "code", "em",
      "font", "kbd", "plaintext", "small", "strike", "strong", "sub", "sup", "tt",
      "var"
   };
   localparam string PLAIN_TAGS [10] = '{
      "p", "div", "br", "table", "plaintexts", "strongest", "/p", "h1", "x9", "/ /b"
   };
   localparam string ENTITIES [3] = '{"&amp;", "&#160;", "&nbsp;"};
   localparam string SEPARATORS = " \n\t.,-";
   localparam string TAG_JUNK = "aZ/ 9<&;";

   typedef struct packed {
      logic                        kind;
      logic [TEXT_BITS-1:0]        char_value;
      logic [WORD_LENGTH_BITS-1:0] word_length;
      logic                        last;
   } token_t;

   class html_token_board;
      token_t          pending_tokens[$];
      int unsigned     failures;
      bit              high_letters;
      mode_type        mode;
      logic [7:0]      name_buf [NAME_CHARS];
      int unsigned     name_len;
      bit              name_open;
      bit              slash_ok;
      int unsigned     run_len;

      function new();
         failures = 0;
         high_letters = 0;
         restart();
      endfunction

      function void restart();
         mode = MODE_IDLE;
         name_len = 0;
         name_open = 1;
         slash_ok = 1;
         run_len = 0;
      endfunction

      function int unsigned waiting();
         return pending_tokens.size();
      endfunction

      function bit is_letter(logic [7:0] c);
         return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
                (c >= "A" && c <= "Z") || (high_letters && c >= 8'h80);
      endfunction

      function bit tag_is_inline();
         bit same;
         foreach (INLINE_NAMES[k]) begin
            if (INLINE_NAMES[k].len() == name_len) begin
               same = 1;
               for (int j = 0; j < name_len; j++) begin
                  if (name_buf[j] != INLINE_NAMES[k][j]) same = 0;
               end
               if (same) return 1;
            end
         end
         return 0;
      endfunction

      function void push_char(logic [7:0] c);
         if (run_len < LENGTH_MAX) run_len++;
         pending_tokens.push_back(token_t'{1'b0, c, '0, 1'b1});
      endfunction

      function void push_end();
         pending_tokens.push_back(token_t'{1'b1, 8'h00, run_len[WORD_LENGTH_BITS-1:0], 1'b1});
         run_len = 0;
      endfunction

      function void outside_byte(logic [7:0] c);
         if (c == CH_LT) begin
            mode = MODE_TAG;
         end else if (c == CH_AMP) begin
            mode = MODE_ENT;
         end else if (is_letter(c)) begin
            run_len = 0;
            mode = MODE_WORD;
            push_char(c);
         end else begin
            mode = MODE_IDLE;
         end
      endfunction

      // Notes one accepted text beat and queues the tokens it must produce.
      function void take_byte(logic [7:0] c);
         bit skip_slash;
         if (c == CH_NUL) begin
            if (mode inside {MODE_WORD, MODE_WTAG, MODE_WAFTER}) push_end();
            restart();
            return;
         end
         case (mode)
            MODE_TAG: begin
               if (c == CH_GT) mode = MODE_IDLE;
            end
            MODE_ENT: begin
               if (c == CH_SEMI) mode = MODE_IDLE;
            end
            MODE_WORD: begin
               if (is_letter(c)) begin
                  push_char(c);
               end else if (c == CH_LT) begin
                  mode = MODE_WTAG;
                  name_len = 0;
                  name_open = 1;
                  slash_ok = 1;
               end else begin
                  push_end();
                  outside_byte(c);
               end
            end
            MODE_WTAG: begin
               if (c == CH_GT) begin
                  if (tag_is_inline()) begin
                     mode = MODE_WAFTER;
                  end else begin
                     mode = MODE_IDLE;
                     push_end();
                  end
               end else begin
                  skip_slash = name_open && slash_ok && name_len == 0 && c == CH_SLASH;
                  if (!skip_slash) begin
                     if (name_open && name_len < NAME_CHARS && is_letter(c)) begin
                        name_buf[name_len] = (c >= "A" && c <= "Z") ? 8'(c + 8'd32) : c;
                        name_len++;
                     end else begin
                        name_open = 0;
                     end
                  end
                  slash_ok = 0;
               end
            end
            MODE_WAFTER: begin
               if (is_letter(c)) begin
                  mode = MODE_WORD;
                  push_char(c);
               end else begin
                  push_end();
                  outside_byte(c);
               end
            end
            default: outside_byte(c);
         endcase
      endfunction

      function void match_token(token_t got);
         token_t want;
         if (pending_tokens.size() == 0) begin
            $error("unexpected result beat: kind %0d char_value 0x%02h word_length %0d",
                   got.kind, got.char_value, got.word_length);
            failures++;
            return;
         end
         want = pending_tokens.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            failures++;
         end
         if (got.char_value !== want.char_value) begin
            $error("char_value: expected 0x%02h, actual 0x%02h", want.char_value,
                   got.char_value);
            failures++;
         end
         if (got.word_length !== want.word_length) begin
            $error("word_length: expected %0d, actual %0d", want.word_length,
                   got.word_length);
            failures++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;

   htok_req_if req_bus();
   htok_rsp_if rsp_bus();

   html_word_tokenizer_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   html_token_board board = new();
   logic [7:0]  text_bytes[$];
   int unsigned bytes_sent;
   int unsigned tokens_seen;
   int unsigned cycles;
   int          stall_left;
   bit          steady;
   bit          send_calm;
   bit          recv_calm;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Result side: ready follows a countdown set after every accepted beat.
   initial begin
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready <= 0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      token_t got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.kind, rsp_bus.char_value, rsp_bus.word_length, rsp_bus.last};
         board.match_token(got);
         tokens_seen++;
         if (tokens_seen % 50 == 0) recv_calm = ($urandom_range(0, 3) == 0);
         // One long hold lets the block fill up and push back on the text side.
         if (tokens_seen == 100 && !steady) stall_left = LONG_HOLD;
         else stall_left = (steady || recv_calm) ? 0 : $urandom_range(0, 6);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (bytes_sent % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
      gap = (steady || send_calm) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1;
      req_bus.text_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      board.take_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_queued();
      while (text_bytes.size() != 0) send_byte(text_bytes.pop_front());
   endtask

   task automatic settle();
      req_bus.valid <= 0;
      do @(negedge clock); while (board.waiting() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_high_bytes(input bit value);
      @(negedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= HIGH_BYTES_ADDR;
      pwdata <= CSR_DATA_BITS'(value);
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      board.high_letters = value;
      // Read the register back right after the write.
      penable <= 0;
      pwrite <= 0;
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      if (prdata !== CSR_DATA_BITS'(value)) begin
         $error("high_bytes_letters: expected 0x%08h, actual 0x%08h",
                CSR_DATA_BITS'(value), prdata);
         board.failures++;
      end
      @(negedge clock);
      psel <= 0;
      penable <= 0;
   endtask

   task automatic add_text(input string s);
      for (int k = 0; k < s.len(); k++) text_bytes.push_back(s[k]);
   endtask

   function automatic logic [7:0] any_case(input logic [7:0] c);
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) return 8'(c - 8'd32);
      return c;
   endfunction

   task automatic add_word();
      int pick;
      repeat ($urandom_range(1, 8)) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) text_bytes.push_back(8'("a" + $urandom_range(0, 25)));
         else if (pick <= 7) text_bytes.push_back(8'("A" + $urandom_range(0, 25)));
         else if (pick == 8) text_bytes.push_back(8'("0" + $urandom_range(0, 9)));
         else text_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
      end
   endtask

   task automatic add_inline_tag();
      string name;
      name = INLINE_NAMES[$urandom_range(0, 20)];
      text_bytes.push_back(CH_LT);
      if ($urandom_range(0, 2) == 0) text_bytes.push_back(CH_SLASH);
      for (int k = 0; k < name.len(); k++) text_bytes.push_back(any_case(name[k]));
      if ($urandom_range(0, 3) == 0) add_text(" id=q");
      text_bytes.push_back(CH_GT);
   endtask

   // Mostly well-formed HTML pieces, with some noise and broken markup mixed in.
   task automatic add_fragment();
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4: add_word();
         5, 6: text_bytes.push_back(SEPARATORS[$urandom_range(0, SEPARATORS.len() - 1)]);
         7, 8, 9: add_inline_tag();
         10, 11: begin
            text_bytes.push_back(CH_LT);
            add_text(PLAIN_TAGS[$urandom_range(0, 9)]);
            text_bytes.push_back(CH_GT);
         end
         12: add_text(ENTITIES[$urandom_range(0, 2)]);
         13, 14, 15: begin
            add_word();
            add_inline_tag();
            add_word();
         end
         16: text_bytes.push_back(8'($urandom_range(1, 255)));
         17: repeat ($urandom_range(1, 4)) text_bytes.push_back(8'($urandom_range(0, 255)));
         18: text_bytes.push_back(CH_NUL);
         default: begin
            text_bytes.push_back(CH_LT);
            repeat ($urandom_range(0, 5)) begin
               text_bytes.push_back(TAG_JUNK[$urandom_range(0, TAG_JUNK.len() - 1)]);
            end
            if ($urandom_range(0, 1)) text_bytes.push_back(CH_GT);
         end
      endcase
   endtask

   task automatic send_random(input int unsigned count);
      int unsigned done;
      done = 0;
      while (done < count) begin
         if (text_bytes.size() == 0) add_fragment();
         send_byte(text_bytes.pop_front());
         done++;
      end
      text_bytes.delete();
   endtask

   initial begin
      reset = 1;
      req_bus.valid = 0;
      req_bus.text_byte = '0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      bytes_sent = 0;
      tokens_seen = 0;
      stall_left = 0;
      steady = 0;
      send_calm = 0;
      recv_calm = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Plain ASCII words: inline tags with a slash, a tag right after an inline
      // tag, a skipped tag and entity, ignored high and control bytes, and a zero
      // byte that cuts off a tag inside a word.
      write_high_bytes(0);
      add_text("Az9</B>x<i><p>&;");
      text_bytes.push_back(8'hFF);
      text_bytes.push_back(8'h01);
      add_text("m<a");
      text_bytes.push_back(CH_NUL);
      send_queued();
      settle();

      // High bytes count as letters, also inside a tag name.
      write_high_bytes(1);
      text_bytes.push_back(8'h80);
      text_bytes.push_back(8'hFF);
      text_bytes.push_back(CH_LT);
      text_bytes.push_back(8'hC3);
      text_bytes.push_back(CH_GT);
      text_bytes.push_back(8'h7F);
      send_queued();
      send_random(400);
      settle();

      // A long word, sent without gaps on either side.
      write_high_bytes(0);
      steady = 1;
      repeat (LONG_WORD) text_bytes.push_back(8'("a" + $urandom_range(0, 25)));
      text_bytes.push_back(CH_SPACE);
      send_queued();
      settle();
      steady = 0;
      send_random(400);
      settle();

      write_high_bytes(1);
      send_random(400);
      settle();

      if (board.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
